FILE: sv/lqh_pkg.sv
// ----------------------------------------------------------------------------
// lqh_pkg
// Shared types and constants for the letter/quality histogram block.
// ----------------------------------------------------------------------------
package lqh_pkg;

   // Operation codes
   localparam logic OP_COUNT = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_LETTER  = 2'd1;
   localparam logic [1:0] STATUS_QUALITY = 2'd2;

   // Base letters and the rows they map to
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_T = 8'h54;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_N = 8'h4E;

   localparam logic [2:0] ROW_A = 3'd0;
   localparam logic [2:0] ROW_T = 3'd1;
   localparam logic [2:0] ROW_G = 3'd2;
   localparam logic [2:0] ROW_C = 3'd3;
   localparam logic [2:0] ROW_N = 3'd4;

   localparam int NUM_ROWS = 5;

   localparam logic [7:0] QUALITY_OFFSET_RESET = 8'd33;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       opcode;
      logic [7:0] base_char;
      logic [7:0] qual_char;
      logic       end_of_read;
      logic [2:0] read_row;
      logic [5:0] read_bin;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] count_value;
      logic        read_done;
   } rsp_type;

   // Classified item, as queued for the back end
   typedef struct packed {
      logic       opcode;
      logic [1:0] status;
      logic       done;
      logic [2:0] row;
      logic [7:0] bin;
   } job_type;

endpackage

FILE: sv/lqh_front.sv
// ----------------------------------------------------------------------------
// lqh_front
// Accepts items, holds the quality offset and classifies each item into a
// row, a bin and a status before it enters the queue.
// ----------------------------------------------------------------------------
module lqh_front
   import lqh_pkg::*;
#(
   parameter int NUM_BINS = 60
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       clear_busy,
   input  logic       queue_full,
   output logic       queue_push,
   output job_type    queue_job
);

   logic [7:0] offset_ff;
   logic [7:0] offset_in;
   logic [2:0] letter_row;
   logic       letter_ok;
   logic [7:0] count_bin;

   assign offset_in = csr_wr_en ? csr_wr_data : offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= QUALITY_OFFSET_RESET;
      end else begin
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      letter_ok  = 1'b1;
      letter_row = ROW_A;
      unique case (req_payload.base_char)
         CHAR_A:  letter_row = ROW_A;
         CHAR_T:  letter_row = ROW_T;
         CHAR_G:  letter_row = ROW_G;
         CHAR_C:  letter_row = ROW_C;
         CHAR_N:  letter_row = ROW_N;
         default: letter_ok  = 1'b0;
      endcase
   end

   // bin wraps modulo 256
   assign count_bin = req_payload.qual_char - offset_ff;

   always_comb begin
      queue_job.opcode = req_payload.opcode;
      if (req_payload.opcode == OP_COUNT) begin
         queue_job.row  = letter_row;
         queue_job.bin  = count_bin;
         queue_job.done = req_payload.end_of_read;
         priority if (!letter_ok) begin
            queue_job.status = STATUS_LETTER;
         end else if ({1'b0, count_bin} >= 9'(NUM_BINS)) begin
            queue_job.status = STATUS_QUALITY;
         end else begin
            queue_job.status = STATUS_OK;
         end
      end else begin
         queue_job.row  = req_payload.read_row;
         queue_job.bin  = 8'(req_payload.read_bin);
         queue_job.done = 1'b0;
         priority if (req_payload.read_row > ROW_N) begin
            queue_job.status = STATUS_LETTER;
         end else if (9'(req_payload.read_bin) >= 9'(NUM_BINS)) begin
            queue_job.status = STATUS_QUALITY;
         end else begin
            queue_job.status = STATUS_OK;
         end
      end
   end

   assign req_ready  = !queue_full && !clear_busy;
   assign queue_push = req_valid && req_ready;

endmodule

FILE: sv/lqh_queue.sv
// ----------------------------------------------------------------------------
// lqh_queue
// Short first-in first-out queue of classified items between the front
// and the back end.
// ----------------------------------------------------------------------------
module lqh_queue
   import lqh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head_job,
   output logic    empty
);

   job_type                  slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;
   logic                     do_push;
   logic                     do_pop;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   assign wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QUEUE_CNT_W'(1);
         2'b01:   count_in = count_ff - QUEUE_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: sv/lqh_back.sv
// ----------------------------------------------------------------------------
// lqh_back
// Counter memory with its clearing pass, read-modify-write sequencer and
// result register.
// ----------------------------------------------------------------------------
module lqh_back
   import lqh_pkg::*;
#(
   parameter int NUM_BINS    = 60,
   parameter int COUNT_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  job_type head_job,
   input  logic    queue_empty,
   output logic    queue_pop,
   output logic    clear_busy,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int MEM_DEPTH = NUM_ROWS * NUM_BINS;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_ISSUE,
      ST_UPDATE
   } state_type;

   state_type               state_ff;
   state_type               state_in;
   logic [ADDR_W-1:0]       clr_ff;
   logic [ADDR_W-1:0]       clr_in;
   logic [ADDR_W-1:0]       addr_ff;
   logic [ADDR_W-1:0]       addr_in;
   job_type                 cur_ff;
   job_type                 cur_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;

   logic [COUNT_WIDTH-1:0]  mem [MEM_DEPTH];
   logic [COUNT_WIDTH-1:0]  rd_data_ff;
   logic                    mem_re;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [COUNT_WIDTH-1:0]  mem_wdata;
   logic [ADDR_W-1:0]       issue_addr;
   logic [COUNT_WIDTH-1:0]  bumped;
   logic                    out_free;
   logic                    cur_ok;

   assign issue_addr = ADDR_W'(ADDR_W'(head_job.row) * ADDR_W'(NUM_BINS))
                       + ADDR_W'(head_job.bin);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cur_ok     = (cur_ff.status == STATUS_OK);

   // hold at the top value
   assign bumped = (rd_data_ff == {COUNT_WIDTH{1'b1}}) ? rd_data_ff
                                                        : rd_data_ff + COUNT_WIDTH'(1);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      queue_pop    = 1'b0;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = bumped;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               mem_re    = (head_job.status == STATUS_OK);
               addr_in   = issue_addr;
               cur_in    = head_job;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // wait for the result register to drain
            if (out_free) begin
               mem_we               = cur_ok && (cur_ff.opcode == OP_COUNT);
               rsp_valid_in         = 1'b1;
               rsp_in.status        = cur_ff.status;
               rsp_in.read_done     = cur_ff.done;
               rsp_in.count_value   = (cur_ok && (cur_ff.opcode == OP_READ))
                                      ? 32'(rd_data_ff) : '0;
               state_in             = ST_ISSUE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff <= addr_in;
      cur_ff  <= cur_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[issue_addr];
      end
   end

   assign clear_busy  = (state_ff == ST_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: sv/letter_quality_histogram.sv
// ----------------------------------------------------------------------------
// letter_quality_histogram
// Two-dimensional histogram of base calls by letter row and quality bin.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  req_      in         req_valid / req_ready   req_type (count or read item)
//  rsp_      out        rsp_valid / rsp_ready   rsp_type (one result per item)
//  csr_      in         csr_wr_en               csr_wr_data (quality offset)
//
//  For each item the back end reads the counter memory into its registered
//  read port, then writes the updated count and loads the result register
//  once that register is free; only then does it take the next item. The
//  front accepts into a 4-entry queue, so it keeps taking items while a
//  result waits on rsp_ready, until the queue fills. After reset a clearing
//  pass zeroes all 5 * NUM_BINS counters; req_ready stays low through it.
// ----------------------------------------------------------------------------
module letter_quality_histogram
   import lqh_pkg::*;
#(
   parameter int NUM_BINS    = 60,
   parameter int COUNT_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic    clear_busy;
   logic    queue_full;
   logic    queue_empty;
   logic    queue_push;
   logic    queue_pop;
   job_type push_job;
   job_type head_job;

   lqh_front #(
      .NUM_BINS (NUM_BINS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .clear_busy  (clear_busy),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_job   (push_job)
   );

   lqh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   lqh_back #(
      .NUM_BINS    (NUM_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .clear_busy  (clear_busy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // no transfer in while the counters are being cleared
   a_no_req_during_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_ready)
      else $error("req_ready high during clearing pass");

   a_no_rsp_during_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !rsp_valid)
      else $error("result presented during clearing pass");

   a_error_has_no_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STATUS_OK) |-> rsp_payload.count_value == '0)
      else $error("nonzero count on a flagged result");

   a_queue_empty_after_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> queue_empty)
      else $error("queue holds items during clearing pass");

endmodule

FILE: tb/letter_quality_histogram_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// letter_quality_histogram_checker
// Watches the request, response and register ports of the histogram block.
// It keeps its own copy of the counter array and the quality offset, works
// out the response for every request transfer and compares each response
// transfer, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module letter_quality_histogram_checker
   import lqh_pkg::*;
#(
   parameter int NUM_BINS    = 60,
   parameter int COUNT_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_payload,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_payload,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int         pending_results,
   output int         mismatch_count
);

   localparam int NUM_CELLS = NUM_ROWS * NUM_BINS;

   logic [COUNT_WIDTH-1:0] cell_counts [NUM_CELLS];
   logic [7:0]             offset_q;
   rsp_type                predicted_rsp [$];
   rsp_type                oldest_rsp;
   int                     errors = 0;

   function automatic int letter_row(input logic [7:0] letter);
      case (letter)
         CHAR_A:  return int'(ROW_A);
         CHAR_T:  return int'(ROW_T);
         CHAR_G:  return int'(ROW_G);
         CHAR_C:  return int'(ROW_C);
         CHAR_N:  return int'(ROW_N);
         default: return -1;
      endcase
   endfunction

   // Apply one request to the counter array and return its response.
   function automatic rsp_type tally_request(input req_type item);
      rsp_type    result;
      logic [7:0] bin;
      int         row;
      int         idx;
      result             = '0;
      result.status      = STATUS_OK;
      result.count_value = '0;
      result.read_done   = 1'b0;
      if (item.opcode == OP_COUNT) begin
         result.read_done = item.end_of_read;
         row = letter_row(item.base_char);
         bin = item.qual_char - offset_q;
         if (row < 0) begin
            result.status = STATUS_LETTER;
         end else if (bin >= NUM_BINS) begin
            result.status = STATUS_QUALITY;
         end else begin
            idx = row * NUM_BINS + int'(bin);
            if (cell_counts[idx] != {COUNT_WIDTH{1'b1}}) begin
               cell_counts[idx] = cell_counts[idx] + 1'b1;
            end
         end
      end else begin
         if (item.read_row >= NUM_ROWS) begin
            result.status = STATUS_LETTER;
         end else if (item.read_bin >= NUM_BINS) begin
            result.status = STATUS_QUALITY;
         end else begin
            idx = int'(item.read_row) * NUM_BINS + int'(item.read_bin);
            result.count_value = 32'(cell_counts[idx]);
         end
      end
      return result;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CELLS; i++) begin
            cell_counts[i] = '0;
         end
         offset_q = QUALITY_OFFSET_RESET;
         predicted_rsp.delete();
      end else begin
         // Check the response first: it can never belong to a request
         // that transfers on this same edge.
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               if (errors < 10) begin
                  $display("%0t: unexpected response: status %0d value %0d done %0b",
                           $realtime, rsp_payload.status, rsp_payload.count_value,
                           rsp_payload.read_done);
               end
               errors++;
            end else begin
               oldest_rsp = predicted_rsp.pop_front();
               if (rsp_payload.status !== oldest_rsp.status ||
                   rsp_payload.count_value !== oldest_rsp.count_value ||
                   rsp_payload.read_done !== oldest_rsp.read_done) begin
                  if (errors < 10) begin
                     $display("%0t: response mismatch: expected status %0d value %0d",
                              $realtime, oldest_rsp.status, oldest_rsp.count_value,
                              " done %0b, got status %0d value %0d done %0b",
                              oldest_rsp.read_done, rsp_payload.status,
                              rsp_payload.count_value, rsp_payload.read_done);
                  end
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted_rsp.push_back(tally_request(req_payload));
         end
         if (csr_wr_en) begin
            offset_q = csr_wr_data;
         end
      end
      pending_results <= predicted_rsp.size();
      mismatch_count  <= errors;
   end

endmodule

FILE: tb/letter_quality_histogram_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// letter_quality_histogram_tb
// Drives count and read requests into the histogram block under several
// quality offsets, with random idle bursts on both channels, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module letter_quality_histogram_tb
   import lqh_pkg::*;
();

   localparam int NUM_BINS    = 60;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REQ_W       = $bits(req_type);

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = '0;

   int         pending_results;
   int         mismatch_count;
   int         idle_pct       = 0;
   int         rsp_stall_left = 0;
   int         cycle_count    = 0;
   logic [7:0] offset_now     = QUALITY_OFFSET_RESET;
   logic [2:0] hot_row        = ROW_A;
   logic [5:0] hot_bin        = '0;

   letter_quality_histogram #(
      .NUM_BINS    (NUM_BINS),
      .COUNT_WIDTH (32)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   letter_quality_histogram_checker #(
      .NUM_BINS    (NUM_BINS),
      .COUNT_WIDTH (32)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side: stall rsp_ready in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = $urandom_range(12, 1) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [7:0] letter_code(input int k);
      case (k)
         0:       return CHAR_A;
         1:       return CHAR_T;
         2:       return CHAR_G;
         3:       return CHAR_C;
         default: return CHAR_N;
      endcase
   endfunction

   // Unused fields carry random junk.
   function automatic req_type count_req(input logic [7:0] base, input logic [7:0] qual,
                                         input logic eor);
      req_type item;
      item             = REQ_W'($urandom);
      item.opcode      = OP_COUNT;
      item.base_char   = base;
      item.qual_char   = qual;
      item.end_of_read = eor;
      return item;
   endfunction

   function automatic req_type read_req(input logic [2:0] row, input logic [5:0] bin);
      req_type item;
      item          = REQ_W'($urandom);
      item.opcode   = OP_READ;
      item.read_row = row;
      item.read_bin = bin;
      return item;
   endfunction

   task automatic make_random(output req_type item);
      int         pick;
      int         k;
      logic [7:0] bin;
      item = REQ_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 65) begin
         k = $urandom_range(4);
         if ($urandom_range(99) < 35) begin
            bin = 8'($urandom_range(3));
         end else if ($urandom_range(99) < 85) begin
            bin = 8'($urandom_range(NUM_BINS - 1));
         end else begin
            bin = 8'($urandom_range(255));
         end
         item = count_req(letter_code(k), offset_now + bin, 1'($urandom_range(1)));
         if (bin < NUM_BINS) begin
            hot_row = 3'(k);
            hot_bin = 6'(bin);
         end
      end else if (pick < 90) begin
         // Read back the cell just counted often, to check a read that follows its update.
         if ($urandom_range(99) < 40) begin
            item = read_req(hot_row, hot_bin);
         end else if ($urandom_range(99) < 85) begin
            item = read_req(3'($urandom_range(NUM_ROWS - 1)),
                            6'($urandom_range(NUM_BINS - 1)));
         end else begin
            item = read_req(3'($urandom_range(7)), 6'($urandom_range(63)));
         end
      end
   endtask

   task automatic send_item(input req_type item);
      int gap;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(12, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold off until every predicted response has transferred.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic write_offset(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      offset_now = value;
   endtask

   task automatic run_phase(input logic [7:0] offset, input int pct, input int count);
      req_type item;
      write_offset(offset);
      idle_pct = pct;
      repeat (count) begin
         make_random(item);
         send_item(item);
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset offset.
      idle_pct = 25;
      send_item(count_req(CHAR_A, 8'd33, 1'b1));
      send_item(count_req(CHAR_A, 8'd33, 1'b0));
      send_item(count_req(CHAR_T, 8'd92, 1'b1));
      send_item(count_req(CHAR_G, 8'd93, 1'b0));
      send_item(count_req(CHAR_C, 8'd32, 1'b1));
      send_item(count_req(CHAR_N, 8'd255, 1'b0));
      send_item(count_req(CHAR_N, 8'd60, 1'b1));
      send_item(count_req(8'h61, 8'd33, 1'b0));
      send_item(count_req(8'h00, 8'd255, 1'b1));
      send_item(count_req(8'hFF, 8'd0, 1'b0));
      send_item(count_req(CHAR_C, 8'd0, 1'b1));
      send_item(count_req(CHAR_G, 8'd34, 1'b0));
      send_item(read_req(ROW_A, 6'd0));
      send_item(read_req(ROW_T, 6'd59));
      send_item(read_req(ROW_N, 6'd27));
      send_item(read_req(ROW_G, 6'd1));
      send_item(read_req(ROW_C, 6'd0));
      send_item(read_req(3'd5, 6'd0));
      send_item(read_req(3'd7, 6'd63));
      send_item(read_req(ROW_N, 6'd60));
      send_item(read_req(ROW_A, 6'd63));
      drain();

      run_phase(8'd0, 30, 110);
      run_phase(8'd255, 0, 100);
      run_phase(8'd64, 50, 110);
      run_phase(8'($urandom), 20, 110);
      run_phase(8'd127, 40, 110);
      run_phase(QUALITY_OFFSET_RESET, 0, 110);

      // Let any stray response show up before the verdict.
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
